// ===== design/stbg_pkg.sv =====
// ----------------------------------------------------------------------------
// stbg_pkg
// Shared types, constants and codes for the sparse tap bloom glow block.
// ----------------------------------------------------------------------------
package stbg_pkg;

  // Frame store geometry.
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int AddrW     = XW + YW;
  localparam int Depth     = MaxWidth * MaxHeight;
  localparam int PixW      = 32;

  // Rec.709 luma weights in Q0.16.
  localparam logic [15:0] WeightR = 16'd13933;
  localparam logic [15:0] WeightG = 16'd46871;
  localparam logic [15:0] WeightB = 16'd4732;

  // Threshold scale: one Q0.8 step is 255 * 256 luma units.
  localparam logic [16:0] ThrScale = 17'd65280;

  // Final division by 255 * 255, done by reciprocal and one correction.
  localparam logic [16:0] DivK     = 17'd65025;
  localparam logic [16:0] RecipM   = 17'd66051;
  localparam logic [27:0] SatLimit = 28'd16646400;

  // Last tap index in the fetch sweep (index 0 is the center pixel).
  localparam logic [3:0] LastFetch  = 4'd8;
  localparam logic [3:0] LastFinish = 4'd6;

  typedef enum logic {
    CmdLoad    = 1'b0,
    CmdCompute = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    RegWidth     = 4'd0,
    RegHeight    = 4'd1,
    RegThreshold = 4'd2,
    RegIntensity = 4'd3,
    RegRadius    = 4'd4,
    RegRed       = 4'd5,
    RegGreen     = 4'd6,
    RegBlue      = 4'd7
  } reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StFinish
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;
    logic       load_we;
    logic       rd_en;
    logic [3:0] rd_idx;
    logic       out_load;
  } ctrl_cmd_t;

endpackage

// ===== design/sparse_tap_bloom_glow.sv =====
// ----------------------------------------------------------------------------
// sparse_tap_bloom_glow
// Frame store with a threshold bloom glow read-out over eight sparse taps.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Word
//  in       in_valid_i/in_stall_o  command, pos_x, pos_y, RGBA
//  out      out_valid_o/out_stall_i  out_red, out_green, out_blue, out_alpha
//  cfg      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A load word writes the frame store at acceptance.
// A compute word makes nine reads of the single-port frame store
// (center and eight taps, one per cycle), then passes a scale, divide
// and saturate pipeline. The output register frees the input side once the
// result is handed over. Reset sets the configuration registers; the frame
// store is not cleared. A stalled output holds the compute in its last step.
// ----------------------------------------------------------------------------
module sparse_tap_bloom_glow
  import stbg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  input  logic [7:0]  in_alpha_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  ctrl_cmd_t cmd;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  stbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  stbg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .in_alpha_i (in_alpha_i),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .out_alpha_o(out_alpha_o)
  );

endmodule

// ===== design/stbg_ram.sv =====
// ----------------------------------------------------------------------------
// stbg_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module stbg_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stbg_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbg_ctrl
// Sequencer: accepts words, sweeps the nine frame reads, then waits out the
// finishing pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module stbg_ctrl
  import stbg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      command_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.rd_idx = cnt_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (command_i == CmdCompute) begin
            cmd_o.start = 1'b1;
            state_d     = StFetch;
            cnt_d       = '0;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      StFetch: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == LastFetch) begin
          state_d = StFinish;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      StFinish: begin
        if (cnt_q == LastFinish) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/stbg_dp.sv =====
// ----------------------------------------------------------------------------
// stbg_dp
// Datapath: configuration registers, frame store, tap address generation,
// luma threshold and accumulate, and the scaling and saturation pipeline.
// ----------------------------------------------------------------------------
module stbg_dp
  import stbg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [7:0] in_red_i,
  input  logic [7:0] in_green_i,
  input  logic [7:0] in_blue_i,
  input  logic [7:0] in_alpha_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);

  // Configuration registers.
  logic [8:0]  width_q, height_q, thr_q;
  logic [11:0] inten_q;
  logic [6:0]  radius_q;
  logic [7:0]  colour_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 9'd256;
      height_q    <= 9'd256;
      thr_q       <= 9'd26;
      inten_q     <= 12'd512;
      radius_q    <= 7'd20;
      colour_q[0] <= 8'd255;
      colour_q[1] <= 8'd255;
      colour_q[2] <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegWidth:     width_q     <= cfg_data_i[8:0];
        RegHeight:    height_q    <= cfg_data_i[8:0];
        RegThreshold: thr_q       <= cfg_data_i[8:0];
        RegIntensity: inten_q     <= cfg_data_i;
        RegRadius:    radius_q    <= cfg_data_i[6:0];
        RegRed:       colour_q[0] <= cfg_data_i[7:0];
        RegGreen:     colour_q[1] <= cfg_data_i[7:0];
        RegBlue:      colour_q[2] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective image edges and radius.
  logic [7:0] xmax, ymax;
  logic [6:0] rad, half;

  always_comb begin
    if (width_q == 9'd0) begin
      xmax = 8'd0;
    end else if (width_q > 9'(MaxWidth)) begin
      xmax = 8'(MaxWidth - 1);
    end else begin
      xmax = 8'(width_q - 9'd1);
    end
    if (height_q == 9'd0) begin
      ymax = 8'd0;
    end else if (height_q > 9'(MaxHeight)) begin
      ymax = 8'(MaxHeight - 1);
    end else begin
      ymax = 8'(height_q - 9'd1);
    end
    rad  = (radius_q == 7'd0) ? 7'd1 : radius_q;
    half = rad >> 1;
  end

  // Clamped center, captured when a compute word is accepted.
  logic [7:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cx_q <= (pos_x_i > xmax) ? xmax : pos_x_i;
      cy_q <= (pos_y_i > ymax) ? ymax : pos_y_i;
    end
  end

  // Tap offset for the current fetch index (index 0 is the center).
  logic signed [7:0] dx, dy;
  logic signed [9:0] sx, sy;
  logic [7:0]        tx, ty;

  always_comb begin
    dx = '0;
    dy = '0;
    case (cmd_i.rd_idx)
      4'd1: dx = -$signed({1'b0, rad});
      4'd2: dx = $signed({1'b0, rad});
      4'd3: dy = -$signed({1'b0, rad});
      4'd4: dy = $signed({1'b0, rad});
      4'd5: begin
        dx = -$signed({1'b0, half});
        dy = -$signed({1'b0, half});
      end
      4'd6: begin
        dx = $signed({1'b0, half});
        dy = -$signed({1'b0, half});
      end
      4'd7: begin
        dx = -$signed({1'b0, half});
        dy = $signed({1'b0, half});
      end
      4'd8: begin
        dx = $signed({1'b0, half});
        dy = $signed({1'b0, half});
      end
      default: ;
    endcase
    sx = $signed({2'b00, cx_q}) + 10'(dx);
    sy = $signed({2'b00, cy_q}) + 10'(dy);
    if (sx < 0) begin
      tx = 8'd0;
    end else if (sx > $signed({2'b00, xmax})) begin
      tx = xmax;
    end else begin
      tx = sx[7:0];
    end
    if (sy < 0) begin
      ty = 8'd0;
    end else if (sy > $signed({2'b00, ymax})) begin
      ty = ymax;
    end else begin
      ty = sy[7:0];
    end
  end

  // Frame store.
  logic [AddrW-1:0] addr;
  logic [PixW-1:0]  rdata;

  assign addr = cmd_i.load_we ? {pos_y_i[YW-1:0], pos_x_i[XW-1:0]}
                              : {ty[YW-1:0], tx[XW-1:0]};

  stbg_ram #(
    .Width(PixW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_we),
    .addr_i (addr),
    .wdata_i({in_alpha_i, in_blue_i, in_green_i, in_red_i}),
    .rdata_o(rdata)
  );

  // Read tracking: read data is valid in the cycle after the request.
  logic rd_v_q, rd_tap_q, s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      rd_tap_q <= 1'b0;
      s1_v_q   <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.rd_en;
      rd_tap_q <= cmd_i.rd_en && (cmd_i.rd_idx != 4'd0);
      s1_v_q   <= rd_v_q && rd_tap_q;
    end
  end

  // Stage 1: luma above threshold for a tap, and center capture.
  logic [23:0] luma;
  logic [25:0] thr_raw;
  logic [23:0] pass_q;
  logic [7:0]  ch_q [3];
  logic [31:0] centre_q;

  always_comb begin
    luma = 24'(WeightR * rdata[7:0]) + 24'(WeightG * rdata[15:8])
         + 24'(WeightB * rdata[23:16]);
    thr_raw = 26'(thr_q * ThrScale);
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      if (rd_tap_q) begin
        ch_q[0] <= rdata[7:0];
        ch_q[1] <= rdata[15:8];
        ch_q[2] <= rdata[23:16];
        pass_q  <= ({2'b00, luma} > thr_raw) ? 24'({2'b00, luma} - thr_raw) : 24'd0;
      end else begin
        centre_q <= rdata;
      end
    end
  end

  // Stage 2: per-channel accumulate of channel times pass weight.
  logic [34:0] acc_q [3];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.start) begin
        acc_q[c] <= '0;
      end else if (s1_v_q) begin
        acc_q[c] <= acc_q[c] + 35'(ch_q[c] * pass_q);
      end
    end
  end

  // Finishing pipeline: scale, divide by 255*255*2^27, add and saturate.
  logic [46:0] p1_q [3];
  logic [54:0] p2_q [3];
  logic [27:0] qv_q [3];
  logic        sat_q [3];
  logic [40:0] qm_q [3];
  logic [7:0]  qe_q [3];
  logic [23:0] qp_q [3];
  logic [27:0] qv2_q [3];
  logic        sat2_q [3];
  logic [23:0] rem [3];
  logic [8:0]  qf [3];
  logic [9:0]  sum [3];
  logic [7:0]  res [3];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      p1_q[c]   <= 47'(acc_q[c] * inten_q);
      p2_q[c]   <= 55'(p1_q[c] * colour_q[c]);
      qv_q[c]   <= p2_q[c][54:27];
      sat_q[c]  <= (p2_q[c][54:27] >= SatLimit);
      qm_q[c]   <= 41'(p2_q[c][50:27] * RecipM);
      qe_q[c]   <= qm_q[c][39:32];
      qp_q[c]   <= 24'(qm_q[c][39:32] * DivK);
      qv2_q[c]  <= qv_q[c];
      sat2_q[c] <= sat_q[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem[c] = qv2_q[c][23:0] - qp_q[c];
      qf[c]  = {1'b0, qe_q[c]} + ((rem[c] >= 24'(DivK)) ? 9'd1 : 9'd0);
      sum[c] = {2'b00, centre_q[8*c +: 8]} + {1'b0, qf[c]};
      res[c] = (sat2_q[c] || (sum[c] > 10'd255)) ? 8'd255 : sum[c][7:0];
    end
  end

  // Output register.
  logic [7:0] out_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q[0] <= res[0];
      out_q[1] <= res[1];
      out_q[2] <= res[2];
      out_q[3] <= centre_q[31:24];
    end
  end

  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];

endmodule

// ===== tb/tb_sparse_tap_bloom_glow.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_tap_bloom_glow
// Self-checking bench for the bloom glow block: loads pixels, computes glowed
// pixels under several register settings and checks each output word against
// a behavioral glow predictor.
// ----------------------------------------------------------------------------
module tb_sparse_tap_bloom_glow
  import stbg_pkg::*;
;

  typedef struct packed {
    logic       cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pix_cmd_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  localparam int WatchLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [7:0]  pos_x_i = '0, pos_y_i = '0;
  logic [7:0]  in_red_i = '0, in_green_i = '0, in_blue_i = '0, in_alpha_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  sparse_tap_bloom_glow i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: its own frame store copy and register copy.
  logic [31:0] pix_mem [Depth];
  logic [11:0] glow_regs [8];
  rgba_t       glow_q [$];
  pix_cmd_t    word_q [$];
  int          errors = 0;
  int          in_gap = 0, out_gap = 0;
  int          idle_cycles = 0;
  bit          driver_hold = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
    errors++;
  endtask

  function automatic int clampc(int v, int size);
    if (v < 0) return 0;
    if (v > size - 1) return size - 1;
    return v;
  endfunction

  function automatic int eff_size(int v, int lim);
    if (v < 1) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // A register keeps only as many bits as its field is wide.
  function automatic logic [11:0] reg_field(reg_e idx, int val);
    case (idx)
      RegWidth, RegHeight, RegThreshold: return 12'(val[8:0]);
      RegIntensity: return val[11:0];
      RegRadius: return 12'(val[6:0]);
      default: return 12'(val[7:0]);
    endcase
  endfunction

  // Glowed pixel at (x,y) under the current register copy.
  function automatic rgba_t glow_pixel(int px, int py);
    int w, h, rad, half, tx, ty;
    int dx [8], dy [8];
    longint unsigned thr, luma, pass, prod, gl, v;
    longint unsigned sum [3];
    longint unsigned ch [3];
    logic [31:0] p, centre;
    rgba_t res;
    w = eff_size(glow_regs[RegWidth], MaxWidth);
    h = eff_size(glow_regs[RegHeight], MaxHeight);
    rad = glow_regs[RegRadius];
    if (rad < 1) rad = 1;
    half = rad / 2;
    dx = '{-rad, rad, 0, 0, -half, half, -half, half};
    dy = '{0, 0, -rad, rad, -half, -half, half, half};
    thr = longint'(glow_regs[RegThreshold]) * 255 * 65536;
    sum = '{0, 0, 0};
    px = clampc(px, w);
    py = clampc(py, h);
    centre = pix_mem[py * MaxWidth + px];
    for (int s = 0; s < 8; s++) begin
      tx = clampc(px + dx[s], w);
      ty = clampc(py + dy[s], h);
      p = pix_mem[ty * MaxWidth + tx];
      for (int c = 0; c < 3; c++) ch[c] = p[8*c +: 8];
      luma = (13933 * ch[0] + 46871 * ch[1] + 4732 * ch[2]) << 8;
      pass = (luma > thr) ? luma - thr : 0;
      for (int c = 0; c < 3; c++) sum[c] += ch[c] * pass;
    end
    for (int c = 0; c < 3; c++) begin
      prod = sum[c] * glow_regs[RegIntensity] * glow_regs[RegRed + c];
      gl = prod / (longint'(65025) << 35);
      v = centre[8*c +: 8] + gl;
      if (c == 0) res.r = (v > 255) ? 8'd255 : v[7:0];
      if (c == 1) res.g = (v > 255) ? 8'd255 : v[7:0];
      if (c == 2) res.b = (v > 255) ? 8'd255 : v[7:0];
    end
    res.a = centre[31:24];
    return res;
  endfunction

  // Driver: present one word from the queue after a random gap.
  always @(negedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      // accepted on the last rising edge; handled there
    end
    if (!in_valid_i && rst_ni && !driver_hold && word_q.size() > 0) begin
      if (in_gap > 0) begin
        in_gap--;
      end else begin
        command_i  <= word_q[0].cmd;
        pos_x_i    <= word_q[0].x;
        pos_y_i    <= word_q[0].y;
        in_red_i   <= word_q[0].r;
        in_green_i <= word_q[0].g;
        in_blue_i  <= word_q[0].b;
        in_alpha_i <= word_q[0].a;
        in_valid_i <= 1'b1;
      end
    end
    // Receiver stall per result word.
    if (out_gap > 0) begin
      out_stall_i <= 1'b1;
      out_gap--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Acceptance of input words feeds the predictor.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      if (command_i == CmdLoad) begin
        pix_mem[{pos_y_i, pos_x_i}] = {in_alpha_i, in_blue_i, in_green_i, in_red_i};
      end else begin
        glow_q.push_back(glow_pixel(pos_x_i, pos_y_i));
      end
      void'(word_q.pop_front());
      in_valid_i <= 1'b0;
      in_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    end
  end

  // Monitor: compare each output word with the oldest expectation.
  always @(posedge clk_i) begin
    rgba_t e;
    if (out_valid_o && !out_stall_i) begin
      if (glow_q.size() == 0) begin
        $display("output word with no expectation");
        errors++;
      end else begin
        e = glow_q.pop_front();
        if (out_red_o !== e.r) report_mismatch("red", out_red_o, e.r);
        if (out_green_o !== e.g) report_mismatch("green", out_green_o, e.g);
        if (out_blue_o !== e.b) report_mismatch("blue", out_blue_o, e.b);
        if (out_alpha_o !== e.a) report_mismatch("alpha", out_alpha_o, e.a);
      end
      out_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input reg_e idx, input int val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val[11:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    glow_regs[idx] = reg_field(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every queued word is in and every expected word has left.
  task automatic drain();
    while (word_q.size() > 0 || in_valid_i || glow_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic push_word(input logic cmd, input int x, input int y, input logic [31:0] d);
    pix_cmd_t t;
    t = {cmd, x[7:0], y[7:0], d[7:0], d[15:8], d[23:16], d[31:24]};
    word_q.push_back(t);
  endtask

  // Fill a w x h image with random or bright pixels.
  task automatic load_image(input int w, input int h, input bit bright);
    logic [31:0] d;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        d = $urandom();
        if (bright && $urandom_range(0, 1)) d[23:0] = 24'hFFFFFF;
        push_word(CmdLoad, x, y, d);
      end
  endtask

  task automatic set_all(input int w, input int h, input int thr, input int inten,
                         input int rad, input int cr, input int cg, input int cb);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegThreshold, thr);
    write_reg(RegIntensity, inten);
    write_reg(RegRadius, rad);
    write_reg(RegRed, cr);
    write_reg(RegGreen, cg);
    write_reg(RegBlue, cb);
  endtask

  initial begin
    int w, h;
    glow_regs = '{12'd256, 12'd256, 12'd26, 12'd512, 12'd20, 12'd255, 12'd255, 12'd255};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: small image, extremes of every register.
    set_all(8, 8, 0, 2560, 1, 255, 255, 255);
    load_image(8, 8, 1'b1);
    push_word(CmdLoad, 0, 0, 32'h00000000);
    push_word(CmdLoad, 7, 7, 32'hFFFFFFFF);
    push_word(CmdCompute, 0, 0, 0);
    push_word(CmdCompute, 7, 7, 32'hFFFFFFFF);
    push_word(CmdCompute, 255, 255, 0);
    push_word(CmdCompute, 3, 200, 0);
    drain();
    set_all(0, 0, 256, 4095, 0, 0, 128, 1);
    push_word(CmdCompute, 5, 5, 0);
    push_word(CmdCompute, 0, 0, 0);
    drain();
    set_all(8, 8, 300, 4095, 127, 255, 0, 255);
    push_word(CmdCompute, 4, 4, 0);
    push_word(CmdCompute, 2, 6, 0);
    drain();

    // Pressure: sender waits for all results before continuing.
    driver_hold = 1'b1;
    drain();
    driver_hold = 1'b0;

    // Random phases over a few settings; the loaded area covers the image.
    for (int ph = 0; ph < 6; ph++) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 16);
      set_all(w, h, $urandom_range(0, 256), $urandom_range(0, 2560),
              $urandom_range(1, 100), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255));
      load_image(w, h, ph[0]);
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 4) == 0)
          push_word(CmdLoad, $urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom());
        else
          push_word(CmdCompute, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
      end
      drain();
    end
    // Loads anywhere in the store (no computes read outside the image).
    for (int i = 0; i < 100; i++)
      push_word(CmdLoad, $urandom_range(0, 255), $urandom_range(0, 255), $urandom());
    drain();

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
